@@ rtl/core/spc_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot pattern checker package
// Word types, register indexes and reset values shared by the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

	localparam int CFG_DATA_W  = 21;
	localparam int SIZE_W      = 17;
	localparam int LIMIT_W     = 21;
	localparam int SEAM_IDX_W  = 20;
	localparam int COUNT_W     = 21;

	localparam logic [SIZE_W-1:0]     SLOT_BYTES_RST = 17'd4096;
	localparam logic [LIMIT_W-1:0]    SLOT_LIMIT_RST = 21'd1048576;
	localparam logic                  SEAM_EN_RST    = 1'b0;
	localparam logic [SEAM_IDX_W-1:0] SEAM_IDX_RST   = 20'd0;

	typedef enum logic [1:0] {
		CFG_SLOT_BYTES  = 2'd0,
		CFG_SLOT_LIMIT  = 2'd1,
		CFG_SEAM_ENABLE = 2'd2,
		CFG_SEAM_INDEX  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_word_t;

	typedef struct packed {
		logic [COUNT_W-1:0] checked_count;
		logic [COUNT_W-1:0] bad_count;
		logic               pass_flag;
	} out_word_t;

endpackage

`default_nettype wire

@@ rtl/core/slot_pattern_checker.sv @@
// ----------------------------------------------------------------------------
// Slot pattern checker
// Checks that a byte stream is made of uniform slots whose values count up.
// ----------------------------------------------------------------------------
// The source channel (src_valid, src_stall, src_data) carries one byte of the
// stream per word, with a flag on the final byte. The destination channel
// (dst_valid, dst_stall, dst_data) carries one report word per stream: the
// number of whole slots checked, the number of bad slots and a pass flag.
// A byte is taken into an input register, processed from there against the
// slot state, and on the final byte the report is loaded into the output
// register, from which it is offered. One byte is accepted every cycle but
// while a final byte waits in the input register behind a stalled report.
// When the receiver stalls, a pending report holds, and bytes keep flowing
// until the next final byte reaches the input register, which then waits.
// Reset clears the slot state and loads the registers with their defaults.
// The configuration port must be written only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_pattern_checker #(
	parameter int MAX_SLOT_BYTES = 65536,
	parameter int MAX_SLOTS      = 1048576
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire spc_pkg::cfg_reg_t               cfg_index,
	input  wire logic [spc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            src_valid,
	output logic                                 src_stall,
	input  wire spc_pkg::in_word_t               src_data,
	output logic                                 dst_valid,
	input  wire logic                            dst_stall,
	output spc_pkg::out_word_t                   dst_data
);

	import spc_pkg::*;

	localparam int PW  = $clog2(MAX_SLOT_BYTES + 1);
	localparam int SZW = (PW > SIZE_W) ? PW : SIZE_W;
	localparam int SW  = $clog2(MAX_SLOTS + 1);
	localparam int CW  = (SW > LIMIT_W) ? SW : LIMIT_W;

	logic [SIZE_W-1:0]     slot_bytes_q;
	logic [LIMIT_W-1:0]    slot_limit_q;
	logic                  seam_enable_q;
	logic [SEAM_IDX_W-1:0] seam_index_q;

	logic                  valid_s1;
	in_word_t              word_s1;

	logic [PW-1:0]         byte_pos_q;
	logic [SW-1:0]         slot_num_q;
	logic [7:0]            slot_value_q;
	logic                  slot_uniform_q;
	logic [7:0]            prev_value_q;
	logic                  prev_valid_q;
	logic [COUNT_W-1:0]    checked_q;
	logic [COUNT_W-1:0]    bad_q;

	logic                  out_valid_q;
	out_word_t             out_word_q;

	logic                  advance;
	logic                  accept;

	logic [SZW-1:0]        size_eff;
	logic [CW-1:0]         limit_eff;
	logic                  active;
	logic [PW-1:0]         pos_inc;
	logic                  slot_done;
	logic                  seam;
	logic                  seq_ok;
	logic [7:0]            value_nx;
	logic                  uniform_nx;
	logic [PW-1:0]         pos_nx;
	logic [SW-1:0]         slot_num_nx;
	logic [7:0]            prev_value_nx;
	logic                  prev_valid_nx;
	logic [COUNT_W-1:0]    checked_nx;
	logic [COUNT_W-1:0]    bad_nx;

	assign advance   = valid_s1 & (~word_s1.end_of_buffer | ~out_valid_q | ~dst_stall);
	assign src_stall = valid_s1 & ~advance;
	assign accept    = src_valid & ~src_stall;
	assign dst_valid = out_valid_q;
	assign dst_data  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q  <= SLOT_BYTES_RST;
			slot_limit_q  <= SLOT_LIMIT_RST;
			seam_enable_q <= SEAM_EN_RST;
			seam_index_q  <= SEAM_IDX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SLOT_BYTES:  slot_bytes_q  <= cfg_data[SIZE_W-1:0];
				CFG_SLOT_LIMIT:  slot_limit_q  <= cfg_data[LIMIT_W-1:0];
				CFG_SEAM_ENABLE: seam_enable_q <= cfg_data[0];
				CFG_SEAM_INDEX:  seam_index_q  <= cfg_data[SEAM_IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (slot_bytes_q == '0) begin
			size_eff = SZW'(1);
		end else if (SZW'(slot_bytes_q) > SZW'(MAX_SLOT_BYTES)) begin
			size_eff = SZW'(MAX_SLOT_BYTES);
		end else begin
			size_eff = SZW'(slot_bytes_q);
		end

		if (CW'(slot_limit_q) > CW'(MAX_SLOTS)) begin
			limit_eff = CW'(MAX_SLOTS);
		end else begin
			limit_eff = CW'(slot_limit_q);
		end

		active = CW'(slot_num_q) < limit_eff;

		if (byte_pos_q == '0) begin
			value_nx   = word_s1.data_byte;
			uniform_nx = 1'b1;
		end else begin
			value_nx   = slot_value_q;
			uniform_nx = slot_uniform_q & (word_s1.data_byte == slot_value_q);
		end

		pos_inc   = byte_pos_q + PW'(1);
		slot_done = SZW'(pos_inc) >= size_eff;

		seam   = seam_enable_q & (CW'(slot_num_q) == CW'(seam_index_q) + CW'(1));
		seq_ok = ~prev_valid_q | seam | (value_nx == prev_value_q + 8'd1);

		pos_nx        = byte_pos_q;
		slot_num_nx   = slot_num_q;
		prev_value_nx = prev_value_q;
		prev_valid_nx = prev_valid_q;
		checked_nx    = checked_q;
		bad_nx        = bad_q;

		if (active) begin
			if (slot_done) begin
				pos_nx        = '0;
				slot_num_nx   = slot_num_q + SW'(1);
				prev_value_nx = value_nx;
				prev_valid_nx = 1'b1;
				checked_nx    = checked_q + COUNT_W'(1);
				if (!uniform_nx || !seq_ok) begin
					bad_nx = bad_q + COUNT_W'(1);
				end
			end else begin
				pos_nx = pos_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= src_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q     <= '0;
			slot_num_q     <= '0;
			slot_value_q   <= '0;
			slot_uniform_q <= 1'b1;
			prev_value_q   <= '0;
			prev_valid_q   <= 1'b0;
			checked_q      <= '0;
			bad_q          <= '0;
		end else if (advance) begin
			if (word_s1.end_of_buffer) begin
				byte_pos_q     <= '0;
				slot_num_q     <= '0;
				slot_value_q   <= '0;
				slot_uniform_q <= 1'b1;
				prev_value_q   <= '0;
				prev_valid_q   <= 1'b0;
				checked_q      <= '0;
				bad_q          <= '0;
			end else if (active) begin
				byte_pos_q     <= pos_nx;
				slot_num_q     <= slot_num_nx;
				slot_value_q   <= value_nx;
				slot_uniform_q <= uniform_nx | slot_done;
				prev_value_q   <= prev_value_nx;
				prev_valid_q   <= prev_valid_nx;
				checked_q      <= checked_nx;
				bad_q          <= bad_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && word_s1.end_of_buffer) begin
			out_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.end_of_buffer) begin
			out_word_q.checked_count <= checked_nx;
			out_word_q.bad_count     <= bad_nx;
			out_word_q.pass_flag     <= (bad_nx == '0);
		end
	end

endmodule

`default_nettype wire

@@ bench/tb_slot_pattern_checker.sv @@
// ----------------------------------------------------------------------------
// Slot pattern checker testbench
// Streams directed and random byte buffers through the checker with random
// gaps on the source and stalls on the report side. A scoreboard class
// predicts each report and compares it field by field with the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_slot_pattern_checker;

	import spc_pkg::*;

	localparam int MAX_SLOT_BYTES = 65536;
	localparam int MAX_SLOTS      = 1048576;
	localparam int DRAIN_CYCLES   = 6;
	localparam int RANDOM_BYTES   = 1300;
	localparam int RANDOM_REPORTS = 48;

	class slot_tally;
		logic [SIZE_W-1:0]     size_reg;
		logic [LIMIT_W-1:0]    limit_reg;
		logic                  seam_en;
		logic [SEAM_IDX_W-1:0] seam_idx;

		int unsigned        byte_pos;
		int unsigned        slot_num;
		logic [7:0]         slot_val;
		bit                 uniform;
		logic [7:0]         prev_val;
		bit                 prev_ok;
		logic [COUNT_W-1:0] checked;
		logic [COUNT_W-1:0] bad;

		out_word_t expected_reports[$];
		int        failures;
		int        reports_seen;

		function new();
			size_reg     = SLOT_BYTES_RST;
			limit_reg    = SLOT_LIMIT_RST;
			seam_en      = SEAM_EN_RST;
			seam_idx     = SEAM_IDX_RST;
			failures     = 0;
			reports_seen = 0;
			clear();
		endfunction

		function void clear();
			byte_pos = 0;
			slot_num = 0;
			slot_val = '0;
			uniform  = 1'b1;
			prev_val = '0;
			prev_ok  = 1'b0;
			checked  = '0;
			bad      = '0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_SLOT_BYTES:  size_reg = val[SIZE_W-1:0];
				CFG_SLOT_LIMIT:  limit_reg = val[LIMIT_W-1:0];
				CFG_SEAM_ENABLE: seam_en = val[0];
				CFG_SEAM_INDEX:  seam_idx = val[SEAM_IDX_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_byte(in_word_t w);
			int unsigned size;
			int unsigned limit;
			bit          seam;
			bit          in_order;
			out_word_t   r;
			size = (size_reg == 0) ? 1 :
				((size_reg > MAX_SLOT_BYTES) ? MAX_SLOT_BYTES : int'(size_reg));
			limit = (limit_reg > MAX_SLOTS) ? MAX_SLOTS : int'(limit_reg);
			if (slot_num < limit) begin
				if (byte_pos == 0) begin
					slot_val = w.data_byte;
					uniform  = 1'b1;
				end else if (w.data_byte != slot_val) begin
					uniform = 1'b0;
				end
				byte_pos++;
				if (byte_pos >= size) begin
					seam = seam_en && (slot_num > 0) && ((slot_num - 1) == seam_idx);
					in_order = !prev_ok || seam || (slot_val == prev_val + 8'd1);
					checked = checked + 1'b1;
					if (!uniform || !in_order)
						bad = bad + 1'b1;
					prev_val = slot_val;
					prev_ok  = 1'b1;
					slot_num++;
					byte_pos = 0;
					uniform  = 1'b1;
				end
			end
			if (w.end_of_buffer) begin
				r.checked_count = checked;
				r.bad_count     = bad;
				r.pass_flag     = (bad == 0);
				expected_reports.push_back(r);
				clear();
			end
		endfunction

		function void check_report(out_word_t got);
			out_word_t want;
			reports_seen++;
			if (expected_reports.size() == 0) begin
				$error("unexpected report: checked_count %0d bad_count %0d pass_flag %0d",
					got.checked_count, got.bad_count, got.pass_flag);
				failures++;
			end else begin
				want = expected_reports.pop_front();
				if (got.checked_count !== want.checked_count) begin
					$error("checked_count: expected %0d, got %0d",
						want.checked_count, got.checked_count);
					failures++;
				end
				if (got.bad_count !== want.bad_count) begin
					$error("bad_count: expected %0d, got %0d", want.bad_count, got.bad_count);
					failures++;
				end
				if (got.pass_flag !== want.pass_flag) begin
					$error("pass_flag: expected %0d, got %0d", want.pass_flag, got.pass_flag);
					failures++;
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  src_valid;
	logic                  src_stall;
	in_word_t              src_data;
	logic                  dst_valid;
	logic                  dst_stall;
	out_word_t             dst_data;

	slot_tally   tally;
	logic [7:0]  directed_q[$];
	bit          src_quiet;
	bit          sink_quiet;
	int unsigned stall_left;
	int unsigned random_bytes;

	slot_pattern_checker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			tally.check_report(dst_data);
			stall_left = sink_quiet ? 0 : $urandom_range(0, 6);
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			dst_stall <= 1'b1;
			stall_left--;
		end else begin
			dst_stall <= 1'b0;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		tally.write_reg(idx, val);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] size_v,
		input logic [CFG_DATA_W-1:0] limit_v, input logic seam_v,
		input logic [CFG_DATA_W-1:0] idx_v);
		write_reg(CFG_SLOT_BYTES, size_v);
		write_reg(CFG_SLOT_LIMIT, limit_v);
		write_reg(CFG_SEAM_ENABLE, CFG_DATA_W'(seam_v));
		write_reg(CFG_SEAM_INDEX, idx_v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eob);
		int       gap;
		in_word_t w;
		gap = src_quiet ? 0 : $urandom_range(0, 6);
		w.data_byte     = b;
		w.end_of_buffer = eob;
		repeat (gap) begin
			@(negedge clk);
			src_valid <= 1'b0;
		end
		@(negedge clk);
		src_valid <= 1'b1;
		src_data  <= w;
		do @(posedge clk); while (src_stall);
		tally.note_byte(w);
	endtask

	task automatic send_directed(input bit close);
		for (int i = 0; i < directed_q.size(); i++)
			send_byte(directed_q[i], close && (i == directed_q.size() - 1));
	endtask

	task automatic settle();
		@(negedge clk);
		src_valid <= 1'b0;
		while (tally.expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly counting slots with random faults; one stream in ten is pure noise.
	task automatic send_stream(input int unsigned pat);
		int unsigned slots;
		int unsigned tail;
		int unsigned total;
		bit          noise;
		logic [7:0]  val;
		logic [7:0]  b;
		slots = $urandom_range(0, 6);
		tail  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, pat - 1) : 0;
		total = slots * pat + tail;
		if (total == 0)
			total = 1;
		noise = ($urandom_range(0, 9) == 0);
		val   = 8'($urandom);
		for (int i = 0; i < total; i++) begin
			if (i != 0 && (i % pat) == 0)
				val = ($urandom_range(0, 7) == 0) ? 8'($urandom) : val + 8'd1;
			b = val;
			if (noise || $urandom_range(0, 39) == 0)
				b = 8'($urandom);
			send_byte(b, i == total - 1);
		end
		random_bytes += total;
	endtask

	task automatic random_phase();
		int unsigned           pat;
		int unsigned           streams;
		logic [CFG_DATA_W-1:0] size_v;
		logic [CFG_DATA_W-1:0] limit_v;
		logic [CFG_DATA_W-1:0] idx_v;
		pat    = $urandom_range(1, 8);
		size_v = CFG_DATA_W'(pat);
		if (pat == 1 && $urandom_range(0, 1) == 1)
			size_v = '0;
		if ($urandom_range(0, 11) == 0)
			size_v = CFG_DATA_W'($urandom_range(9, 131071));
		case ($urandom_range(0, 7))
			0: limit_v = '0;
			1: limit_v = 1;
			2: limit_v = 2;
			3, 4: limit_v = CFG_DATA_W'($urandom_range(3, 12));
			5: limit_v = CFG_DATA_W'(MAX_SLOTS);
			6: limit_v = 21'h1FFFFF;
			default: limit_v = CFG_DATA_W'($urandom);
		endcase
		idx_v = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFFF) :
			$urandom_range(0, 8));
		src_quiet  = ($urandom_range(0, 3) == 0);
		sink_quiet = ($urandom_range(0, 3) == 0);
		configure(size_v, limit_v, 1'($urandom_range(0, 1)), idx_v);
		streams = $urandom_range(2, 6);
		repeat (streams) send_stream(pat);
		settle();
	endtask

	initial begin
		tally        = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_SLOT_BYTES;
		cfg_data     = '0;
		src_valid    = 1'b0;
		src_data     = '0;
		dst_stall    = 1'b0;
		src_quiet    = 1'b0;
		sink_quiet   = 1'b0;
		stall_left   = 0;
		random_bytes = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Bytes after the slot limit are ignored.
		configure(2, 2, 1'b0, 0);
		directed_q = '{8'd17, 8'd17, 8'd18, 8'd18, 8'd40};
		send_directed(1'b1);
		settle();

		// Zero slot size acts as one byte; wrap from 255 to 0; seam exempts one break.
		configure(0, 21'h1FFFFF, 1'b1, 1);
		directed_q = '{8'd255, 8'd0, 8'd9, 8'd3};
		send_directed(1'b1);
		settle();

		configure(3, 0, 1'b0, 0);
		directed_q = '{8'd1, 8'd2, 8'd3};
		send_directed(1'b1);
		settle();

		// A non-uniform slot, then a trailing partial slot.
		configure(3, CFG_DATA_W'(MAX_SLOTS), 1'b0, 21'hFFFFF);
		directed_q = '{8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd8, 8'd0, 8'd0};
		send_directed(1'b1);
		settle();

		// The slot size shrinks under a slot that is partly filled.
		configure(4, CFG_DATA_W'(MAX_SLOTS), 1'b0, 0);
		directed_q = '{8'd3, 8'd3, 8'd3};
		send_directed(1'b0);
		settle();
		configure(2, CFG_DATA_W'(MAX_SLOTS), 1'b0, 0);
		directed_q = '{8'd3, 8'd4, 8'd4};
		send_directed(1'b1);
		settle();

		while (random_bytes < RANDOM_BYTES || tally.reports_seen < RANDOM_REPORTS)
			random_phase();

		if (tally.failures == 0)
			$display("slot_pattern_checker verification clean");
		else
			$display("slot_pattern_checker verification failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("slot_pattern_checker verification failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/spc_pkg.sv
rtl/core/slot_pattern_checker.sv
bench/tb_slot_pattern_checker.sv
